// ===== hdl/tmos_pkg.sv =====
// Shared types and constants of the temporal median unit.
package tmos_pkg;

  localparam int unsigned SAMPLE_W       = 8;
  localparam int unsigned MAX_FRAMES_DEF = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

// ===== hdl/tmos_in_if.sv =====
// Sample request channel: one pixel sample and its end-of-group flag.
interface tmos_in_if;
  import tmos_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== hdl/tmos_out_if.sv =====
// Result request channel: median of a finished group and its drop flag.
interface tmos_out_if;
  import tmos_pkg::*;

  logic    valid;
  logic    ready;
  sample_t median_value;
  logic    overflow;

  modport source (output valid, output median_value, output overflow, input ready);
  modport sink   (input valid, input median_value, input overflow, output ready);
endinterface

// ===== hdl/temporal_median_of_samples_unit.sv =====
// Per-pixel temporal median: insertion-sorted sample store with median readout.
//
// Samples of one pixel group arrive one per request and are kept in ascending
// order in a single-port-write, single-port-read memory of MAX_FRAMES entries.
// An insertion walks down from the top of the sorted run one entry per cycle,
// moving every larger entry up by one; no new sample is taken while it runs.
// A sample into an empty store is written straight to index 0. After a sample
// flagged last_sample the unit reads the entry at index count/2 (StMedRd,
// then StMedOut), which is the upper median for an even count; the result waits
// in an output register while the next group begins. Samples that arrive when
// the store is full are dropped and reported through overflow on the group's
// result. The store needs no clearing after reset: only entries written in the
// current group are ever read.
module temporal_median_of_samples_unit #(
  parameter int unsigned MAX_FRAMES = tmos_pkg::MAX_FRAMES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmos_in_if.sink    in_i,
  tmos_out_if.source out_o
);
  import tmos_pkg::*;

  localparam int unsigned AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StShift = 5'b00010,
    StPlace = 5'b00100,
    StMedRd = 5'b01000,
    StMedOut = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  sample_t       val_q, val_d;
  logic          last_q, last_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] count_q, count_d;
  logic          drop_q, drop_d;
  logic          out_valid_q, out_valid_d;
  sample_t       out_med_q, out_med_d;
  logic          out_ovf_q, out_ovf_d;

  logic          we;
  logic [AW-1:0] waddr;
  sample_t       wdata;
  logic          re;
  logic [AW-1:0] raddr;
  sample_t       rdata;
  logic          accept;
  logic [CW-1:0] half_count;

  tmos_store #(
    .Depth (MAX_FRAMES),
    .AddrW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_i.ready         = (state_q == StIdle);
  assign accept             = in_i.valid && in_i.ready;
  assign half_count         = count_q >> 1;
  assign out_o.valid        = out_valid_q;
  assign out_o.median_value = out_med_q;
  assign out_o.overflow     = out_ovf_q;

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    last_d      = last_q;
    pos_d       = pos_q;
    count_d     = count_q;
    drop_d      = drop_q;
    out_med_d   = out_med_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    we          = 1'b0;
    waddr       = '0;
    wdata       = val_q;
    re          = 1'b0;
    raddr       = '0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          val_d  = in_i.sample;
          last_d = in_i.last_sample;
          if (count_q < CW'(MAX_FRAMES)) begin
            if (count_q == '0) begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = in_i.sample;
              count_d = count_q + CW'(1);
              state_d = in_i.last_sample ? StMedRd : StIdle;
            end else begin
              // Fetch the current top of the sorted run to start the walk down.
              re      = 1'b1;
              raddr   = count_q[AW-1:0] - AW'(1);
              pos_d   = count_q[AW-1:0];
              state_d = StShift;
            end
          end else begin
            drop_d  = 1'b1;
            state_d = in_i.last_sample ? StMedRd : StIdle;
          end
        end
      end

      StShift: begin
        if (rdata > val_q) begin
          // Move the larger entry up one place and look at the next one down.
          we    = 1'b1;
          waddr = pos_q;
          wdata = rdata;
          pos_d = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = StPlace;
          end else begin
            re    = 1'b1;
            raddr = pos_q - AW'(2);
          end
        end else begin
          we      = 1'b1;
          waddr   = pos_q;
          wdata   = val_q;
          count_d = count_q + CW'(1);
          state_d = last_q ? StMedRd : StIdle;
        end
      end

      StPlace: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        count_d = count_q + CW'(1);
        state_d = last_q ? StMedRd : StIdle;
      end

      StMedRd: begin
        re      = 1'b1;
        raddr   = half_count[AW-1:0];
        state_d = StMedOut;
      end

      StMedOut: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_med_d   = rdata;
          out_ovf_d   = drop_q;
          count_d     = '0;
          drop_d      = 1'b0;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    last_q    <= last_d;
    pos_q     <= pos_d;
    out_med_q <= out_med_d;
    out_ovf_q <= out_ovf_d;
  end

endmodule

// ===== hdl/tmos_store.sv =====
// Sorted sample store: one write port and one read port with registered read data.
module tmos_store #(
  parameter int unsigned Depth = tmos_pkg::MAX_FRAMES_DEF,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  tmos_pkg::sample_t wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output tmos_pkg::sample_t rdata_o
);
  import tmos_pkg::*;

  sample_t mem_q [Depth];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
